/* sv/gaussian_blur_kernel_weights_macros.svh */
// Assertion macros shared by the Gaussian weight generator checkers.
`ifndef GAUSSIAN_BLUR_KERNEL_WEIGHTS_MACROS_SVH
`define GAUSSIAN_BLUR_KERNEL_WEIGHTS_MACROS_SVH

// Same-cycle implication under reset.
`define GBKW_ASSERT_SAME(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under reset.
`define GBKW_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/gbkw_pkg.sv */
// Package: types, constants and elaboration-time tables of the Gaussian weight generator.
package gbkw_pkg;

    localparam int SIGMA_W         = 12;
    localparam int TAP_W           = 5;
    localparam int WEIGHT_W        = 16;
    localparam int RADIUS_W        = 4;
    localparam int S_TDATA_W       = 16;
    localparam int M_TDATA_W       = 24;
    localparam int DEF_MAX_RADIUS  = 8;
    localparam int DEF_WEIGHT_BITS = 16;

    localparam logic [SIGMA_W-1:0] SIGMA_RESET = 12'd256;

    // Divider: 48-bit dividend, 24-bit divisor (sigma squared fits in 24 bits)
    localparam int DIV_W     = 48;
    localparam int DVS_W     = 24;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // Shared multiplier operand widths
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 32;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam int ACC_W   = 33;
    localparam int GAIN_W  = 16;
    localparam int TOTAL_W = 21;
    localparam int RECIP_W = 32;

    localparam logic [31:0]      E_INV_Q32 = 32'd1580030169;
    localparam logic [ACC_W-1:0] ONE_Q32   = 33'h1_0000_0000;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ,
        ST_SQW,
        ST_XDIV,
        ST_XWAIT,
        ST_EINT,
        ST_EINTW,
        ST_EFRAC,
        ST_EFRACW,
        ST_STORE,
        ST_RDIV,
        ST_RWAIT,
        ST_LKX,
        ST_LKXM,
        ST_LKYM,
        ST_LKPY,
        ST_LKW,
        ST_LKR,
        ST_FIN
    } gbkw_state_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    // Bitwise integer square root, elaboration use only
    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bitv;
        v    = v_in;
        res  = 64'd0;
        bitv = 64'h4000_0000_0000_0000;
        for (int j = 0; j < 32; j++)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // e^(-2^(i-16)) in Q0.32 for fraction bit i, from the square-root chain
    function automatic logic [15:0][31:0] root_table();
        logic [15:0][31:0] tab;
        logic [63:0]       r;
        r = {32'd0, E_INV_Q32};
        for (int j = 0; j < 16; j++)
        begin
            r           = isqrt64(r << 32);
            tab[15 - j] = r[31:0];
        end
        return tab;
    endfunction

    localparam logic [15:0][31:0] ROOT_TAB = root_table();

endpackage

/* sv/gbkw_div.sv */
// Restoring divider, one quotient bit per cycle.
module gbkw_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  gbkw_pkg::div_req_t        req,
    output logic                      done,
    output logic [gbkw_pkg::DIV_W-1:0] quotient
);
    import gbkw_pkg::*;

    logic [DVS_W-1:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DVS_W-1:0]     dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DVS_W:0]       trial;
    logic [DVS_W:0]       diff;

    // One shift-subtract step
    always_comb
    begin
        trial     = {rem_reg, quo_reg[DIV_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
            cnt_next  = DIV_CNT_W'(DIV_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = diff[DVS_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DVS_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* sv/gbkw_mul.sv */
// Shared multiplier with registered product.
module gbkw_mul (
    input  logic                         clk,
    input  logic [gbkw_pkg::MUL_A_W-1:0] a,
    input  logic [gbkw_pkg::MUL_B_W-1:0] b,
    output logic [gbkw_pkg::PROD_W-1:0]  prod
);
    import gbkw_pkg::*;

    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign prod = prod_reg;

endmodule

/* sv/gbkw_row_ram.sv */
// 1-D gain table: one write port, one registered read port.
module gbkw_row_ram #(
    parameter int DEPTH = gbkw_pkg::DEF_MAX_RADIUS + 1,
    parameter int AW    = $clog2(gbkw_pkg::DEF_MAX_RADIUS + 1)
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [gbkw_pkg::GAIN_W-1:0] wdata,
    input  logic [AW-1:0]               raddr,
    output logic [gbkw_pkg::GAIN_W-1:0] rdata
);
    import gbkw_pkg::*;

    logic [GAIN_W-1:0] mem [DEPTH];
    logic [GAIN_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/gaussian_blur_kernel_weights.sv */
// Normalized 2-D Gaussian kernel weight generator, one tap per transfer.
//
// Channels: cfg_we/cfg_wdata writes sigma (unsigned Q4.8). s_tdata carries a
// tap offset (dx, dy); each accepted transfer yields one m_tdata transfer with
// the weight (Q0.16), an in-range flag, the radius and a clamp flag.
// Writes to sigma are to be made only while the block is idle; it is not enforced.
// Throughput: one tap at a time; s_tready is low from acceptance until the
// result has been loaded into the output register.
// With the table built, a tap inside the radius looks up both 1-D gains,
// scales each by the reciprocal and multiplies them; one outside gets zero
// weight. The first tap after reset or a sigma write also builds the 1-D
// gain table term by term up to the radius, each exponent from its integer
// part and its set fraction bits; a term whose exponent reaches 16 is zero.
// The build uses the shared divider and the shared multiplier.
// Reset: sigma returns to 1.0, the table is marked not built, no output valid.
// A stalled m_tready holds the result in the output register; a new tap may
// still be accepted and computed meanwhile, and waits before loading.
module gaussian_blur_kernel_weights #(
    parameter int MAX_RADIUS  = gbkw_pkg::DEF_MAX_RADIUS,
    parameter int WEIGHT_BITS = gbkw_pkg::DEF_WEIGHT_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [gbkw_pkg::SIGMA_W-1:0]   cfg_wdata,   // sigma_q4_8
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [gbkw_pkg::S_TDATA_W-1:0] s_tdata,     // [4:0] tap_dx, [9:5] tap_dy
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [15:0] weight, [16] inside_res, [20:17] radius, [21] radius_clamped
    output logic [gbkw_pkg::M_TDATA_W-1:0] m_tdata
);
    import gbkw_pkg::*;

    localparam int DEPTH   = MAX_RADIUS + 1;
    localparam int AW      = $clog2(MAX_RADIUS + 1);
    localparam int W_SHIFT = 62 - WEIGHT_BITS;
    localparam logic [PROD_W-1:0] W_HALF = PROD_W'(1) << (W_SHIFT - 1);
    localparam logic [WEIGHT_W-1:0] W_LIM =
        (WEIGHT_BITS >= 16) ? 16'hFFFF : WEIGHT_W'((1 << WEIGHT_BITS) - 1);

    gbkw_state_t state_reg, state_next;

    logic [SIGMA_W-1:0]   sigma_reg, sigma_next;
    logic                 ready_reg, ready_next;
    logic [TAP_W-1:0]     ax_reg, ax_next;
    logic [TAP_W-1:0]     ay_reg, ay_next;
    logic [RADIUS_W-1:0]  k_reg, k_next;
    logic [DVS_W-1:0]     s2_reg, s2_next;
    logic [TOTAL_W-1:0]   total_reg, total_next;
    logic [RECIP_W-1:0]   recip_reg, recip_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [3:0]           cnt_reg, cnt_next;
    logic [15:0]          frac_reg, frac_next;
    logic [3:0]           bit_reg, bit_next;
    logic [31:0]          px_reg, px_next;
    logic [31:0]          py_reg, py_next;
    logic [WEIGHT_W-1:0]  w_reg, w_next;
    logic [M_TDATA_W-1:0] out_reg, out_next;
    logic                 m_valid_reg, m_valid_next;

    logic [13:0]         r_sum;
    logic [5:0]          r_raw;
    logic                clamped;
    logic [RADIUS_W-1:0] radius;
    logic                tap_in;
    logic [TAP_W-1:0]    dx;
    logic [TAP_W-1:0]    dy;
    logic [ACC_W:0]      g_sum;
    logic [GAIN_W-1:0]   g_val;
    logic [7:0]          k_sq;
    logic [PROD_W-1:0]   prod;
    logic [PROD_W-1:0]   rnd32_sum;
    logic [PROD_W-1:0]   rnd16_sum;
    logic [PROD_W-1:0]   w_full;
    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [GAIN_W-1:0]   ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [GAIN_W-1:0]   ram_rdata;
    div_req_t            div_req;
    logic                div_done;
    logic [DIV_W-1:0]    div_q;

    // Radius from sigma: ceil(3 sigma), clamped
    assign r_sum   = 14'(3 * sigma_reg) + 14'd255;
    assign r_raw   = r_sum[13:8];
    assign clamped = (r_raw > 6'(MAX_RADIUS));
    assign radius  = clamped ? RADIUS_W'(MAX_RADIUS) : r_raw[RADIUS_W-1:0];
    assign tap_in  = (ax_reg <= {1'b0, radius}) && (ay_reg <= {1'b0, radius});

    // Signed tap offsets
    assign dx = s_tdata[TAP_W-1:0];
    assign dy = s_tdata[2*TAP_W-1:TAP_W];

    // Gain from accumulator, rounded and saturated
    assign g_sum = {1'b0, acc_reg} + (ACC_W + 1)'(32768);
    assign g_val = (g_sum[ACC_W:16] > (ACC_W - 15)'(65535)) ? 16'hFFFF : g_sum[31:16];
    assign k_sq  = 8'(k_reg) * 8'(k_reg);

    // Product rounding
    assign rnd32_sum = prod + PROD_W'(33'h0_8000_0000);
    assign rnd16_sum = prod + PROD_W'(32768);
    assign w_full    = (prod + W_HALF) >> W_SHIFT;

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        sigma_next   = sigma_reg;
        ready_next   = ready_reg;
        ax_next      = ax_reg;
        ay_next      = ay_reg;
        k_next       = k_reg;
        s2_next      = s2_reg;
        total_next   = total_reg;
        recip_next   = recip_reg;
        acc_next     = acc_reg;
        cnt_next     = cnt_reg;
        frac_next    = frac_reg;
        bit_next     = bit_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        w_next       = w_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_tready;
        mul_a        = '0;
        mul_b        = '0;
        ram_we       = 1'b0;
        ram_waddr    = k_reg[AW-1:0];
        ram_wdata    = g_val;
        ram_raddr    = ax_reg[AW-1:0];
        div_req      = '0;
        s_tready     = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    ax_next = dx[TAP_W-1] ? (~dx + 1'b1) : dx;
                    ay_next = dy[TAP_W-1] ? (~dy + 1'b1) : dy;
                    if (ready_reg)
                    begin
                        state_next = ST_LKX;
                    end
                    else
                    begin
                        // center tap is always full scale
                        k_next     = '0;
                        total_next = '0;
                        acc_next   = ONE_Q32;
                        state_next = ST_STORE;
                    end
                end
            end
            ST_SQ:
            begin
                mul_a      = MUL_A_W'(sigma_reg);
                mul_b      = MUL_B_W'(sigma_reg);
                state_next = ST_SQW;
            end
            ST_SQW:
            begin
                s2_next    = prod[DVS_W-1:0];
                state_next = ST_XDIV;
            end
            ST_XDIV:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'({k_sq, 31'd0}) + DIV_W'(s2_reg[DVS_W-1:1]);
                div_req.divisor  = s2_reg;
                state_next       = ST_XWAIT;
            end
            ST_XWAIT:
            begin
                if (div_done)
                begin
                    if (div_q[DIV_W-1:20] != '0)
                    begin
                        acc_next   = '0;
                        state_next = ST_STORE;
                    end
                    else
                    begin
                        acc_next   = ONE_Q32;
                        cnt_next   = div_q[19:16];
                        frac_next  = div_q[15:0];
                        bit_next   = 4'd15;
                        state_next = ST_EINT;
                    end
                end
            end
            ST_EINT:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_EFRAC;
                end
                else
                begin
                    mul_a      = acc_reg;
                    mul_b      = E_INV_Q32;
                    state_next = ST_EINTW;
                end
            end
            ST_EINTW:
            begin
                acc_next   = rnd32_sum[PROD_W-1:32];
                cnt_next   = cnt_reg - 1'b1;
                state_next = ST_EINT;
            end
            ST_EFRAC:
            begin
                if (frac_reg[bit_reg])
                begin
                    mul_a      = acc_reg;
                    mul_b      = ROOT_TAB[bit_reg];
                    state_next = ST_EFRACW;
                end
                else if (bit_reg == '0)
                begin
                    state_next = ST_STORE;
                end
                else
                begin
                    bit_next = bit_reg - 1'b1;
                end
            end
            ST_EFRACW:
            begin
                acc_next = rnd32_sum[PROD_W-1:32];
                if (bit_reg == '0)
                begin
                    state_next = ST_STORE;
                end
                else
                begin
                    bit_next   = bit_reg - 1'b1;
                    state_next = ST_EFRAC;
                end
            end
            ST_STORE:
            begin
                ram_we     = 1'b1;
                total_next = total_reg + ((k_reg == '0) ? TOTAL_W'(g_val)
                                                        : TOTAL_W'({g_val, 1'b0}));
                k_next     = k_reg + 1'b1;
                if (k_reg == radius)
                begin
                    state_next = ST_RDIV;
                end
                else if (k_reg == '0)
                begin
                    state_next = ST_SQ;
                end
                else
                begin
                    state_next = ST_XDIV;
                end
            end
            ST_RDIV:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(1) << 47;
                div_req.divisor  = DVS_W'(total_reg);
                state_next       = ST_RWAIT;
            end
            ST_RWAIT:
            begin
                if (div_done)
                begin
                    recip_next = div_q[RECIP_W-1:0];
                    ready_next = 1'b1;
                    state_next = ST_LKX;
                end
            end
            ST_LKX:
            begin
                if (tap_in)
                begin
                    state_next = ST_LKXM;
                end
                else
                begin
                    w_next     = '0;
                    state_next = ST_FIN;
                end
            end
            ST_LKXM:
            begin
                mul_a      = MUL_A_W'(ram_rdata);
                mul_b      = recip_reg;
                ram_raddr  = ay_reg[AW-1:0];
                state_next = ST_LKYM;
            end
            ST_LKYM:
            begin
                px_next    = rnd16_sum[47:16];
                mul_a      = MUL_A_W'(ram_rdata);
                mul_b      = recip_reg;
                state_next = ST_LKPY;
            end
            ST_LKPY:
            begin
                py_next    = rnd16_sum[47:16];
                state_next = ST_LKW;
            end
            ST_LKW:
            begin
                mul_a      = MUL_A_W'(px_reg);
                mul_b      = py_reg;
                state_next = ST_LKR;
            end
            ST_LKR:
            begin
                w_next     = (w_full > PROD_W'(W_LIM)) ? W_LIM : w_full[WEIGHT_W-1:0];
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    out_next     = {2'b00, clamped, radius, tap_in, w_reg};
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // sigma write invalidates the table
        if (cfg_we)
        begin
            sigma_next = cfg_wdata;
            ready_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            sigma_reg   <= SIGMA_RESET;
            ready_reg   <= 1'b0;
            recip_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            sigma_reg   <= sigma_next;
            ready_reg   <= ready_next;
            recip_reg   <= recip_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg    <= ax_next;
        ay_reg    <= ay_next;
        k_reg     <= k_next;
        s2_reg    <= s2_next;
        total_reg <= total_next;
        acc_reg   <= acc_next;
        cnt_reg   <= cnt_next;
        frac_reg  <= frac_next;
        bit_reg   <= bit_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        w_reg     <= w_next;
        out_reg   <= out_next;
    end

    gbkw_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    gbkw_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    gbkw_row_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_reg;

endmodule

/* sv/gbkw_checker.sv */
// Port-level checker for the Gaussian weight generator, bound to the top level.
`include "gaussian_blur_kernel_weights_macros.svh"

module gbkw_checker #(
    parameter int MAX_RADIUS = gbkw_pkg::DEF_MAX_RADIUS
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [gbkw_pkg::M_TDATA_W-1:0] m_tdata
);

    // stalled result holds
    `GBKW_ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed under stall")

    // one tap in flight: ready drops after each transfer
    `GBKW_ASSERT_NEXT(a_busy, clk, rst_n, s_tvalid && s_tready, !s_tready, "input taken while busy")

    // out-of-range taps carry zero weight
    `GBKW_ASSERT_SAME(a_zero, clk, rst_n, m_tvalid && !m_tdata[16], m_tdata[15:0] == 16'd0, "nonzero weight outside radius")

    // radius bounded, and at the limit when clamped
    `GBKW_ASSERT_SAME(a_rad, clk, rst_n, m_tvalid, (m_tdata[20:17] <= 4'(MAX_RADIUS)) && (!m_tdata[21] || (m_tdata[20:17] == 4'(MAX_RADIUS))), "radius field inconsistent")

endmodule

bind gaussian_blur_kernel_weights gbkw_checker #(.MAX_RADIUS(MAX_RADIUS)) u_gbkw_checker (.*);

/* tb/gaussian_blur_kernel_weights_test.sv */
// Testbench for the Gaussian kernel weight generator: directed taps, then random taps.
`timescale 1ns / 100ps

module gaussian_blur_kernel_weights_test;

    import gbkw_pkg::*;

    localparam int          MAX_RAD   = 8;
    localparam logic [63:0] E_INV     = 64'd1580030169;
    localparam logic [63:0] ONE_Q32   = 64'h1_0000_0000;
    localparam int          TAP_COUNT = 1600;

    // One tap result as carried on m_tdata
    typedef struct packed {
        logic [15:0] weight;
        logic        inside_res;
        logic [3:0]  radius;
        logic        radius_clamped;
    } tap_result_t;

    // Directed row: either a sigma write or a tap, optionally with a typed result
    typedef struct {
        bit          is_write;
        logic [11:0] sigma;
        logic [4:0]  dx;
        logic [4:0]  dy;
        bit          typed;
        tap_result_t res;
    } tap_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [SIGMA_W-1:0]   cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;    // [4:0] tap_dx, [9:5] tap_dy
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;    // [15:0] weight, [16] inside, [20:17] radius, [21] clamped

    // Model state
    logic [15:0]  gain_row [0:MAX_RAD];
    logic [31:0]  recip_now;
    logic [3:0]   radius_now;
    logic         clamp_now;

    tap_result_t  weight_q[$];
    int           fail_count;
    int           send_idle_pct;
    int           recv_idle_pct;

    gaussian_blur_kernel_weights DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        v   = v_in;
        res = 64'd0;
        b   = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] q32_mul(input logic [63:0] a, input logic [63:0] b);
        return (a * b + (64'd1 << 31)) >> 32;
    endfunction

    // exp(-k^2 / (2 sigma^2)) in Q0.16, sigma nonzero
    function automatic logic [15:0] exp_gain(input int k, input logic [11:0] s);
        logic [63:0] s2;
        logic [63:0] x;
        logic [63:0] acc;
        logic [63:0] root;
        logic [63:0] g;
        s2   = 64'(s) * 64'(s);
        x    = ((64'(k * k) << 31) + s2 / 2) / s2;
        acc  = ONE_Q32;
        root = E_INV;
        if ((x >> 16) >= 16)
            return 16'd0;
        for (int i = 0; i < int'(x >> 16); i++)
            acc = q32_mul(acc, E_INV);
        for (int i = 15; i >= 0; i--)
        begin
            root = int_sqrt(root << 32);
            if (x[i])
                acc = q32_mul(acc, root);
        end
        g = (acc + (64'd1 << 15)) >> 16;
        return (g > 64'd65535) ? 16'hFFFF : g[15:0];
    endfunction

    // Rebuild the 1-D gain row and reciprocal for a new sigma
    task automatic load_sigma(input logic [11:0] s);
        int          r;
        logic [63:0] total;
        r         = (3 * int'(s) + 255) >> 8;
        clamp_now = (r > MAX_RAD);
        if (r > MAX_RAD)
            r = MAX_RAD;
        if (s == 0)
        begin
            r           = 0;
            gain_row[0] = 16'hFFFF;
        end
        else
        begin
            for (int k = 0; k <= r; k++)
                gain_row[k] = exp_gain(k, s);
        end
        radius_now = r[3:0];
        total      = 64'(gain_row[0]);
        for (int k = 1; k <= r; k++)
            total = total + 2 * 64'(gain_row[k]);
        recip_now = (total != 0) ? 32'((64'd1 << 47) / total) : 32'd0;
    endtask

    function automatic tap_result_t predict_weight(input logic [4:0] dx, input logic [4:0] dy);
        tap_result_t r;
        int          ax;
        int          ay;
        logic [63:0] px;
        logic [63:0] py;
        logic [63:0] w;
        ax = dx[4] ? 32 - int'(dx) : int'(dx);
        ay = dy[4] ? 32 - int'(dy) : int'(dy);
        r.inside_res     = (ax <= radius_now) && (ay <= radius_now);
        r.radius         = radius_now;
        r.radius_clamped = clamp_now;
        r.weight         = 16'd0;
        if (r.inside_res)
        begin
            px = (64'(gain_row[ax]) * 64'(recip_now) + (64'd1 << 15)) >> 16;
            py = (64'(gain_row[ay]) * 64'(recip_now) + (64'd1 << 15)) >> 16;
            w  = (px * py + (64'd1 << 45)) >> 46;
            r.weight = (w > 64'd65535) ? 16'hFFFF : w[15:0];
        end
        return r;
    endfunction

    // Sigma write, only with the block drained
    task automatic write_sigma(input logic [11:0] s);
        s_tvalid <= 1'b0;
        while (weight_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= s;
        @(negedge clk);
        cfg_we    <= 1'b0;
        load_sigma(s);
    endtask

    // Present one tap; called at a falling edge, returns at a falling edge
    task automatic send_tap(input logic [4:0] dx, input logic [4:0] dy,
                            input bit typed, input tap_result_t res);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, dy, dx};
        do
            @(posedge clk);
        while (!s_tready);
        weight_q.push_back(typed ? res : predict_weight(dx, dy));
        @(negedge clk);
    endtask

    // Receiver backpressure
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Result checker
    always @(posedge clk)
    begin
        tap_result_t got;
        tap_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.weight         = m_tdata[15:0];
            got.inside_res     = m_tdata[16];
            got.radius         = m_tdata[20:17];
            got.radius_clamped = m_tdata[21];
            if (weight_q.size() == 0)
            begin
                $error("result transfer with nothing expected: %h", m_tdata);
                fail_count++;
            end
            else
            begin
                want = weight_q.pop_front();
                if (got.weight !== want.weight)
                begin
                    $error("weight: expected %0d, got %0d", want.weight, got.weight);
                    fail_count++;
                end
                if (got.inside_res !== want.inside_res)
                begin
                    $error("inside_res: expected %0d, got %0d", want.inside_res, got.inside_res);
                    fail_count++;
                end
                if (got.radius !== want.radius)
                begin
                    $error("radius: expected %0d, got %0d", want.radius, got.radius);
                    fail_count++;
                end
                if (got.radius_clamped !== want.radius_clamped)
                begin
                    $error("radius_clamped: expected %0d, got %0d",
                           want.radius_clamped, got.radius_clamped);
                    fail_count++;
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        tap_row_t    rows[$];
        tap_result_t none;
        logic [11:0] sig;
        logic [4:0]  dx;
        logic [4:0]  dy;
        int          lim;

        none          = '0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        fail_count    = 0;
        send_idle_pct = 17;
        recv_idle_pct = 63;
        load_sigma(SIGMA_RESET);

        // Directed table: reset sigma, beyond radius, minus sixteen, sigma 0, widest sigma, sigma 1, sigma 683
        rows = '{
            '{0, 12'd0,    5'd0,  5'd0,  0, '0},
            '{0, 12'd0,    5'd3,  5'd29, 0, '0},
            '{0, 12'd0,    5'd1,  5'd2,  0, '0},
            '{0, 12'd0,    5'd4,  5'd0,  1, '{16'd0, 1'b0, 4'd3, 1'b0}},
            '{0, 12'd0,    5'd16, 5'd0,  1, '{16'd0, 1'b0, 4'd3, 1'b0}},
            '{0, 12'd0,    5'd0,  5'd15, 1, '{16'd0, 1'b0, 4'd3, 1'b0}},
            '{1, 12'd0,    5'd0,  5'd0,  0, '0},
            '{0, 12'd0,    5'd0,  5'd0,  1, '{16'd65535, 1'b1, 4'd0, 1'b0}},
            '{0, 12'd0,    5'd1,  5'd0,  1, '{16'd0, 1'b0, 4'd0, 1'b0}},
            '{0, 12'd0,    5'd16, 5'd16, 1, '{16'd0, 1'b0, 4'd0, 1'b0}},
            '{1, 12'd4095, 5'd0,  5'd0,  0, '0},
            '{0, 12'd0,    5'd0,  5'd0,  0, '0},
            '{0, 12'd0,    5'd8,  5'd24, 0, '0},
            '{0, 12'd0,    5'd31, 5'd1,  0, '0},
            '{0, 12'd0,    5'd9,  5'd0,  1, '{16'd0, 1'b0, 4'd8, 1'b1}},
            '{0, 12'd0,    5'd16, 5'd8,  1, '{16'd0, 1'b0, 4'd8, 1'b1}},
            '{1, 12'd1,    5'd0,  5'd0,  0, '0},
            '{0, 12'd0,    5'd0,  5'd0,  0, '0},
            '{0, 12'd0,    5'd1,  5'd31, 0, '0},
            '{0, 12'd0,    5'd2,  5'd0,  1, '{16'd0, 1'b0, 4'd1, 1'b0}},
            '{1, 12'd683,  5'd0,  5'd0,  0, '0},
            '{0, 12'd0,    5'd8,  5'd8,  0, '0},
            '{0, 12'd0,    5'd0,  5'd0,  0, '0}
        };

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (rows[i])
        begin
            if (rows[i].is_write)
                write_sigma(rows[i].sigma);
            else
                send_tap(rows[i].dx, rows[i].dy, rows[i].typed, rows[i].res);
        end

        // Random part: three idling phases, several sigmas each
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 63 : 0;
            recv_idle_pct = (ph == 0) ? 63 : (ph == 1) ? 17 : 0;
            for (int sset = 0; sset < 6; sset++)
            begin
                case (sset)
                    0:       sig = 12'd1;
                    1:       sig = 12'd4095;
                    2:       sig = 12'($urandom_range(1, 4095));
                    default: sig = 12'($urandom_range(1, 700));
                endcase
                write_sigma(sig);
                for (int n = 0; n < TAP_COUNT / 18; n++)
                begin
                    // Mostly taps inside the radius, some anywhere
                    if ($urandom_range(99) < 80)
                    begin
                        lim = radius_now;
                        dx  = 5'($urandom_range(0, 2 * lim) - lim);
                        dy  = 5'($urandom_range(0, 2 * lim) - lim);
                    end
                    else
                    begin
                        dx = 5'($urandom);
                        dy = 5'($urandom);
                    end
                    send_tap(dx, dy, 0, none);
                end
            end
        end
        s_tvalid <= 1'b0;

        // Drain
        while (weight_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
